[design/hsfp_pkg.sv]
// Shared widths, reset values, register codes and types for the heat stencil block.
package hsfp_pkg;

   // payload and register widths
   localparam int TEMP_W     = 32;
   localparam int COEF_W     = 16;
   localparam int COLS_W     = 11;
   localparam int ROWS_W     = 16;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;

   // Laplacian term, coefficient product and rounding accumulator widths
   localparam int LAP_W  = TEMP_W + 3;
   localparam int PROD_W = LAP_W + COEF_W + 1;
   localparam int ACC_W  = PROD_W + 2;

   // geometry defaults and limits
   localparam int HSFP_MAX_COLS = 1024;
   localparam logic [COLS_W-1:0] GRID_COLS_RST = COLS_W'(1024);
   localparam logic [ROWS_W-1:0] GRID_ROWS_RST = ROWS_W'(1024);
   localparam int MIN_DIM = 3;

   // register map
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_COEF_X    = 2'd0,
      CSR_COEF_Y    = 2'd1,
      CSR_GRID_COLS = 2'd2,
      CSR_GRID_ROWS = 2'd3
   } hsfp_csr_type;

   // per-beat raster flags
   typedef struct packed {
      logic produce;
      logic last;
   } hsfp_flags_type;

endpackage

[design/hsfp_req_if.sv]
// Input channel: one previous-grid temperature sample per beat.
interface hsfp_req_if import hsfp_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic signed [TEMP_W-1:0] temp_in;

   modport source (output valid, output temp_in, input ready);
   modport sink   (input valid, input temp_in, output ready);
endinterface

[design/hsfp_rsp_if.sv]
// Result channel: one updated interior temperature per beat.
interface hsfp_rsp_if import hsfp_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic signed [TEMP_W-1:0] temp_out;
   logic                     last_point;

   modport source (output valid, output temp_out, output last_point, input ready);
   modport sink   (input valid, input temp_out, input last_point, output ready);
endinterface

[design/hsfp_ram.sv]
// Generic simple dual-port RAM: one write port, one read port with registered data.
module hsfp_ram import hsfp_pkg::*; #(
   parameter int WIDTH = TEMP_W,
   parameter int DEPTH = HSFP_MAX_COLS
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      // read data holds while no read is issued
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[design/hsfp_raster.sv]
// Configuration registers and raster position tracking for the stencil.
module hsfp_raster import hsfp_pkg::*; #(
   parameter int MAX_COLS = HSFP_MAX_COLS
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        csr_wr_en,
   input  logic [CSR_IDX_W-1:0]        csr_index,
   input  logic [CSR_DATA_W-1:0]       csr_wdata,
   input  logic                        step,
   output logic [$clog2(MAX_COLS)-1:0] col,
   output hsfp_flags_type              flags,
   output logic [COEF_W-1:0]           coef_x,
   output logic [COEF_W-1:0]           coef_y
);

   localparam int CW = $clog2(MAX_COLS);

   logic [COEF_W-1:0] coef_x_ff, coef_x_in;
   logic [COEF_W-1:0] coef_y_ff, coef_y_in;
   logic [COLS_W-1:0] grid_cols_ff, grid_cols_in;
   logic [ROWS_W-1:0] grid_rows_ff, grid_rows_in;
   logic [CW-1:0]     col_ff, col_in;
   logic [ROWS_W-1:0] row_ff, row_in;

   logic [31:0]       cols_used;
   logic [CW-1:0]     cols_last;
   logic [ROWS_W-1:0] rows_last;
   logic              col_end;
   logic              row_end;

   // effective geometry: columns clamped to [3, MAX_COLS], rows to at least 3
   always_comb begin
      cols_used = {{(32-COLS_W){1'b0}}, grid_cols_ff};
      if (cols_used < 32'(MIN_DIM)) begin
         cols_used = 32'(MIN_DIM);
      end else if (cols_used > 32'(MAX_COLS)) begin
         cols_used = 32'(MAX_COLS);
      end
      cols_last = CW'(cols_used - 32'd1);
      if (grid_rows_ff < ROWS_W'(MIN_DIM)) begin
         rows_last = ROWS_W'(MIN_DIM - 1);
      end else begin
         rows_last = grid_rows_ff - ROWS_W'(1);
      end
   end

   assign col_end = (col_ff == cols_last);
   assign row_end = (row_ff == rows_last);

   // register writes and raster advance; a geometry write restarts the raster
   always_comb begin
      coef_x_in    = coef_x_ff;
      coef_y_in    = coef_y_ff;
      grid_cols_in = grid_cols_ff;
      grid_rows_in = grid_rows_ff;
      col_in       = col_ff;
      row_in       = row_ff;
      if (step) begin
         if (col_end) begin
            col_in = '0;
            row_in = row_end ? '0 : row_ff + ROWS_W'(1);
         end else begin
            col_in = col_ff + CW'(1);
         end
      end
      if (csr_wr_en) begin
         case (hsfp_csr_type'(csr_index))
            CSR_COEF_X: begin
               coef_x_in = csr_wdata[COEF_W-1:0];
            end
            CSR_COEF_Y: begin
               coef_y_in = csr_wdata[COEF_W-1:0];
            end
            CSR_GRID_COLS: begin
               grid_cols_in = csr_wdata[COLS_W-1:0];
               col_in       = '0;
               row_in       = '0;
            end
            CSR_GRID_ROWS: begin
               grid_rows_in = csr_wdata[ROWS_W-1:0];
               col_in       = '0;
               row_in       = '0;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         coef_x_ff    <= '0;
         coef_y_ff    <= '0;
         grid_cols_ff <= GRID_COLS_RST;
         grid_rows_ff <= GRID_ROWS_RST;
         col_ff       <= '0;
         row_ff       <= '0;
      end else begin
         coef_x_ff    <= coef_x_in;
         coef_y_ff    <= coef_y_in;
         grid_cols_ff <= grid_cols_in;
         grid_rows_ff <= grid_rows_in;
         col_ff       <= col_in;
         row_ff       <= row_in;
      end
   end

   // interior points only; last marks the final interior point of the grid
   assign col           = col_ff;
   assign flags.produce = (row_ff >= ROWS_W'(2)) && (col_ff >= CW'(2));
   assign flags.last    = row_end && col_end;
   assign coef_x        = coef_x_ff;
   assign coef_y        = coef_y_ff;

   // raster position never runs past the effective geometry
   a_pos_in_range: assert property (@(posedge clock) disable iff (reset)
      (col_ff <= cols_last) && (row_ff <= rows_last))
      else $error("raster position beyond grid");

endmodule

[design/hsfp_calc.sv]
// Stencil arithmetic: Laplacian products, rounding, saturation and result register.
module hsfp_calc import hsfp_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     in_valid,
   output logic                     in_ready,
   input  logic                     in_last,
   input  logic signed [TEMP_W-1:0] up,
   input  logic signed [TEMP_W-1:0] down,
   input  logic signed [TEMP_W-1:0] left,
   input  logic signed [TEMP_W-1:0] right,
   input  logic signed [TEMP_W-1:0] ctr,
   input  logic [COEF_W-1:0]        coef_x,
   input  logic [COEF_W-1:0]        coef_y,
   output logic                     out_valid,
   input  logic                     out_ready,
   output logic signed [TEMP_W-1:0] temp_out,
   output logic                     last_point
);

   logic signed [LAP_W-1:0]  lap_x, lap_y;
   logic signed [COEF_W:0]   cx_s, cy_s;
   logic signed [PROD_W-1:0] px_in, py_in;
   logic signed [PROD_W-1:0] px_ff, py_ff;
   logic signed [TEMP_W-1:0] ctr_ff;
   logic                     last_ff;
   logic                     s3_v_ff;

   logic signed [ACC_W-1:0]  acc;
   logic signed [ACC_W-17:0] rnd;
   logic signed [TEMP_W-1:0] sat_in;
   logic signed [TEMP_W-1:0] temp_ff;
   logic                     last_out_ff;
   logic                     out_v_ff;

   logic                     out_rdy;
   logic                     s3_rdy;

   assign out_rdy  = !out_v_ff || out_ready;
   assign s3_rdy   = !s3_v_ff || out_rdy;
   assign in_ready = s3_rdy;

   // exact Laplacian terms, then one multiply each by the Q0.16 coefficient
   always_comb begin
      lap_x = LAP_W'(up) + LAP_W'(down) - (LAP_W'(ctr) <<< 1);
      lap_y = LAP_W'(left) + LAP_W'(right) - (LAP_W'(ctr) <<< 1);
      cx_s  = $signed({1'b0, coef_x});
      cy_s  = $signed({1'b0, coef_y});
      px_in = lap_x * cx_s;
      py_in = lap_y * cy_s;
   end

   // centre (Q16.16) folded in at the 32-fraction-bit product scale plus half an output LSB, then floor shift
   always_comb begin
      acc = ACC_W'(px_ff) + ACC_W'(py_ff) + ACC_W'($signed({ctr_ff, 16'h8000}));
      rnd = acc[ACC_W-1:16];
      if (rnd > (ACC_W-16)'(32'sh7FFF_FFFF)) begin
         sat_in = 32'sh7FFF_FFFF;
      end else if (rnd < -(ACC_W-16)'(64'sh8000_0000)) begin
         sat_in = 32'sh8000_0000;
      end else begin
         sat_in = rnd[TEMP_W-1:0];
      end
   end

   // product stage
   always_ff @(posedge clock) begin
      if (reset) begin
         s3_v_ff <= 1'b0;
      end else if (s3_rdy) begin
         s3_v_ff <= in_valid;
      end
      if (s3_rdy && in_valid) begin
         px_ff   <= px_in;
         py_ff   <= py_in;
         ctr_ff  <= ctr;
         last_ff <= in_last;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff <= 1'b0;
      end else if (out_rdy) begin
         out_v_ff <= s3_v_ff;
      end
      if (out_rdy && s3_v_ff) begin
         temp_ff     <= sat_in;
         last_out_ff <= last_ff;
      end
   end

   assign out_valid  = out_v_ff;
   assign temp_out   = temp_ff;
   assign last_point = last_out_ff;

endmodule

[design/heat_stencil_five_point.sv]
// Top level of the five-point explicit heat equation stencil engine.
// The previous temperature grid, halo rows and columns included, streams in as one
// signed Q16.16 sample per beat in raster order; every interior point produces one
// saturated Q16.16 result, halo points produce none, and the final interior point of
// a grid is flagged with last_point. The block takes one sample per clock when the
// result side keeps up; a result is registered after the sample right below-right of
// it passes stage 1 with the line store read, the 3x3 window, the coefficient product
// register and the rounding/saturation result register. The two line stores are
// RAMs with one read and one write per clock, MAX_COLS words each; they need no
// clearing pass. Writing grid_cols or grid_rows restarts the raster at the top left;
// write configuration only while no beat is in flight.
module heat_stencil_five_point import hsfp_pkg::*; #(
   parameter int MAX_COLS = HSFP_MAX_COLS
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_wr_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   hsfp_req_if.sink              req_chan,
   hsfp_rsp_if.source            rsp_chan
);

   localparam int CW = $clog2(MAX_COLS);

   logic                     req_go;
   logic [CW-1:0]            acc_col;
   hsfp_flags_type           acc_flags;
   logic [COEF_W-1:0]        coef_x;
   logic [COEF_W-1:0]        coef_y;

   logic                     s1_v_ff;
   logic signed [TEMP_W-1:0] s1_x_ff;
   logic [CW-1:0]            s1_col_ff;
   hsfp_flags_type           s1_flags_ff;
   logic                     s1_go;

   logic [TEMP_W-1:0]        older_q;
   logic [TEMP_W-1:0]        newer_q;

   logic signed [TEMP_W-1:0] win_ff [3][3];
   logic                     s2_v_ff;
   logic                     s2_last_ff;

   logic                     rdy1;
   logic                     rdy2;
   logic                     calc_ready;

   // stage handshakes: each stage takes a beat when empty or moving on
   assign rdy2           = !s2_v_ff || calc_ready;
   assign rdy1           = !s1_v_ff || rdy2;
   assign req_chan.ready = rdy1;
   assign req_go         = req_chan.valid && rdy1;
   assign s1_go          = s1_v_ff && rdy2;

   hsfp_raster #(
      .MAX_COLS (MAX_COLS)
   ) u_raster (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .step      (req_go),
      .col       (acc_col),
      .flags     (acc_flags),
      .coef_x    (coef_x),
      .coef_y    (coef_y)
   );

   // line stores: read at accept, rotate older <= newer <= sample when stage 1 moves on
   hsfp_ram #(
      .WIDTH (TEMP_W),
      .DEPTH (MAX_COLS)
   ) u_older_ram (
      .clock   (clock),
      .wr_en   (s1_go),
      .wr_addr (s1_col_ff),
      .wr_data (newer_q),
      .rd_en   (req_go),
      .rd_addr (acc_col),
      .rd_data (older_q)
   );

   hsfp_ram #(
      .WIDTH (TEMP_W),
      .DEPTH (MAX_COLS)
   ) u_newer_ram (
      .clock   (clock),
      .wr_en   (s1_go),
      .wr_addr (s1_col_ff),
      .wr_data (s1_x_ff),
      .rd_en   (req_go),
      .rd_addr (acc_col),
      .rd_data (newer_q)
   );

   // stage 1: accepted sample and its raster info
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff <= 1'b0;
      end else if (rdy1) begin
         s1_v_ff <= req_chan.valid;
      end
      if (req_go) begin
         s1_x_ff     <= req_chan.temp_in;
         s1_col_ff   <= acc_col;
         s1_flags_ff <= acc_flags;
      end
   end

   // stage 2: 3x3 window shifts left on every sample, halo ones too
   always_ff @(posedge clock) begin
      if (reset) begin
         s2_v_ff <= 1'b0;
      end else if (rdy2) begin
         s2_v_ff <= s1_go && s1_flags_ff.produce;
      end
      if (s1_go) begin
         for (int k = 0; k < 3; k++) begin
            win_ff[k][0] <= win_ff[k][1];
            win_ff[k][1] <= win_ff[k][2];
         end
         win_ff[0][2] <= older_q;
         win_ff[1][2] <= newer_q;
         win_ff[2][2] <= s1_x_ff;
         s2_last_ff   <= s1_flags_ff.last;
      end
   end

   hsfp_calc u_calc (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (s2_v_ff),
      .in_ready   (calc_ready),
      .in_last    (s2_last_ff),
      .up         (win_ff[0][1]),
      .down       (win_ff[2][1]),
      .left       (win_ff[1][0]),
      .right      (win_ff[1][2]),
      .ctr        (win_ff[1][1]),
      .coef_x     (coef_x),
      .coef_y     (coef_y),
      .out_valid  (rsp_chan.valid),
      .out_ready  (rsp_chan.ready),
      .temp_out   (rsp_chan.temp_out),
      .last_point (rsp_chan.last_point)
   );

   // a line store never reads the word being written in the same clock
   a_no_rw_collide: assert property (@(posedge clock) disable iff (reset)
      (req_go && s1_go) |-> (acc_col != s1_col_ff))
      else $error("line store read and write collide");

   // stalled stage 1 keeps its line store read data
   a_read_held: assert property (@(posedge clock) disable iff (reset)
      (s1_v_ff && !rdy2) |=> $stable(older_q) && $stable(newer_q))
      else $error("line store data lost during stall");

   // an interior sample leaving stage 1 always loads a window beat
   a_interior_to_window: assert property (@(posedge clock) disable iff (reset)
      (s1_go && s1_flags_ff.produce) |=> s2_v_ff)
      else $error("interior point dropped at window");

endmodule
